>>> design/rmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types, sizes and the combine function of the range-minimum segment
// tree core.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int LEAVES     = 1024;
    localparam int NODE_COUNT = 2 * LEAVES - 1;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    // one-based walk index, must hold 2*LEAVES
    localparam int IDX_W      = $clog2(LEAVES) + 2;
    localparam int LEAF_W     = 10;
    localparam int RANGE_W    = 11;
    localparam int DATA_W     = 64;

    localparam logic [DATA_W-1:0] IDENTITY_RESET = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic
    {
        CMD_SET   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_LEAF,
        ST_SET_READ,
        ST_SET_WRITE,
        ST_QRY_RUN,
        ST_RESULT
    } state_t;

    // identity is neutral, otherwise signed minimum
    function automatic logic [DATA_W-1:0] combine(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] id
    );
        logic [DATA_W-1:0] r;
        if (a == id)
        begin
            r = b;
        end
        else if (b == id)
        begin
            r = a;
        end
        else if ($signed(b) < $signed(a))
        begin
            r = b;
        end
        else
        begin
            r = a;
        end
        return r;
    endfunction

endpackage

>>> design/range_min_segment_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_segment_tree_core
// Segment tree of signed 64-bit values with single-leaf set and half-open
// range-minimum query, built around one node memory and one combine unit.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  cmd       in         cmd_valid / cmd_stall  command, leaf_index, range_low,
//                                              range_high, new_value
//  res       out        res_valid / res_stall  min_value
//  cfg       in         cfg_wr_en              cfg_wr_data (identity value)
//
//  after reset a clearing pass writes the identity reset value into all 2047
//  nodes, one node per cycle, while cmd_stall stays high
//  a set writes the leaf, then does one read of the sibling and one write of
//  the parent per level through the single memory port
//  a query walks the tree bottom-up: each level of the walk reads at most
//  two boundary nodes, one read per cycle
//  one transaction is worked on at a time; a result holds while res_stall is
//  high and the next command is taken once it has been delivered
//
module range_min_segment_tree_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic                              command,
    input  logic [rmst_pkg::LEAF_W-1:0]       leaf_index,
    input  logic [rmst_pkg::RANGE_W-1:0]      range_low,
    input  logic [rmst_pkg::RANGE_W-1:0]      range_high,
    input  logic signed [rmst_pkg::DATA_W-1:0] new_value,
    // result channel
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [rmst_pkg::DATA_W-1:0] min_value,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic signed [rmst_pkg::DATA_W-1:0] cfg_wr_data
);
    import rmst_pkg::*;

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;      // node of the set walk
    logic [IDX_W-1:0]    lo_reg, lo_next;        // one-based left bound
    logic [IDX_W-1:0]    hi_reg, hi_next;        // one-based right bound
    logic                pend_reg, pend_next;    // read data waits for combine
    logic [DATA_W-1:0]   acc_reg, acc_next;      // running value / result
    logic [DATA_W-1:0]   identity_reg;

    // node memory, one port
    logic [DATA_W-1:0]   tree_mem [NODE_COUNT];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [DATA_W-1:0]   mem_wdata;

    // decode of the incoming command
    logic                cmd_accept;
    logic                is_query;
    logic                leaf_ok;
    logic                q_empty;
    logic [IDX_W-1:0]    q_hi_clamp;

    // shared combine unit and walk arithmetic
    logic [DATA_W-1:0]   comb_out;
    logic [ADDR_W-1:0]   pos_sibling;
    logic [ADDR_W-1:0]   pos_parent;
    logic [ADDR_W-1:0]   pos_m1;
    logic [IDX_W-1:0]    lo_m1;
    logic [IDX_W-1:0]    hi_m2;
    logic                walk_live;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign is_query   = (command == CMD_QUERY);
    assign leaf_ok    = (int'(leaf_index) < LEAVES);
    // empty, reversed, or starting past the last leaf
    assign q_empty    = (range_low >= range_high) || (int'(range_low) >= LEAVES);
    // part of the range past the last leaf adds nothing
    assign q_hi_clamp = (int'(range_high) > LEAVES) ? IDX_W'(LEAVES) : IDX_W'(range_high);

    assign comb_out    = combine(acc_reg, rd_data_reg, identity_reg);
    assign pos_m1      = pos_reg - ADDR_W'(1);
    assign pos_sibling = pos_reg[0] ? (pos_reg + ADDR_W'(1)) : pos_m1;
    assign pos_parent  = pos_m1 >> 1;
    assign lo_m1       = lo_reg - IDX_W'(1);
    assign hi_m2       = hi_reg - IDX_W'(2);
    assign walk_live   = (lo_reg < hi_reg);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (is_query)
                    begin
                        state_next = q_empty ? ST_RESULT : ST_QRY_RUN;
                    end
                    else if (leaf_ok)
                    begin
                        state_next = ST_SET_LEAF;
                    end
                end
            end
            ST_SET_LEAF:
            begin
                state_next = ST_SET_READ;
            end
            ST_SET_READ:
            begin
                // root already rebuilt
                state_next = (pos_reg == '0) ? ST_IDLE : ST_SET_WRITE;
            end
            ST_SET_WRITE:
            begin
                state_next = ST_SET_READ;
            end
            ST_QRY_RUN:
            begin
                if (!walk_live)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------- datapath and memory control
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pend_next    = pend_reg;
        acc_next     = acc_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = pos_reg;
        mem_wdata    = acc_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = IDENTITY_RESET;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    // leaf i lives at node LEAVES-1+i
                    pos_next  = ADDR_W'(LEAVES - 1) + ADDR_W'(leaf_index);
                    lo_next   = IDX_W'(range_low) + IDX_W'(LEAVES);
                    hi_next   = q_hi_clamp + IDX_W'(LEAVES);
                    pend_next = 1'b0;
                    acc_next  = is_query ? identity_reg : new_value;
                end
            end
            ST_SET_LEAF:
            begin
                mem_we    = 1'b1;
                mem_addr  = pos_reg;
                mem_wdata = acc_reg;
            end
            ST_SET_READ:
            begin
                if (pos_reg != '0)
                begin
                    mem_re   = 1'b1;
                    mem_addr = pos_sibling;
                end
            end
            ST_SET_WRITE:
            begin
                acc_next  = comb_out;
                mem_we    = 1'b1;
                mem_addr  = pos_parent;
                mem_wdata = comb_out;
                pos_next  = pos_parent;
            end
            ST_QRY_RUN:
            begin
                // fold in the node read last cycle
                if (pend_reg)
                begin
                    acc_next = comb_out;
                end
                pend_next = 1'b0;
                if (walk_live)
                begin
                    if (lo_reg[0])
                    begin
                        mem_re    = 1'b1;
                        mem_addr  = lo_m1[ADDR_W-1:0];
                        lo_next   = lo_reg + IDX_W'(1);
                        pend_next = 1'b1;
                    end
                    else if (hi_reg[0])
                    begin
                        mem_re    = 1'b1;
                        mem_addr  = hi_m2[ADDR_W-1:0];
                        hi_next   = hi_reg - IDX_W'(1);
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        // both bounds aligned, climb one level
                        lo_next = lo_reg >> 1;
                        hi_next = hi_reg >> 1;
                    end
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            identity_reg <= IDENTITY_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            if (cfg_wr_en)
            begin
                identity_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        acc_reg <= acc_next;
    end

    // node memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= tree_mem[mem_addr];
        end
    end

    // ---------------------------------------------------------------- outputs
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign min_value = acc_reg;

endmodule

>>> design/rmst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks of the range-minimum segment tree core, bound to the top.
// ----------------------------------------------------------------------------
module rmst_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_stall,
    input  logic                              command,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  logic signed [rmst_pkg::DATA_W-1:0] min_value
);
    import rmst_pkg::*;

    // no new command is taken while a result is pending
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall)
        else $error("command channel open while a result is pending");

    // a set transaction never produces a result
    a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (command == CMD_SET)) |=> !res_valid)
        else $error("result after a set transaction");

    // a query keeps the core busy until its result is delivered
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (command == CMD_QUERY)) |=> cmd_stall)
        else $error("core idle right after a query transaction");

    // stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(min_value)))
        else $error("stalled result changed");

endmodule

bind range_min_segment_tree_core rmst_checker u_rmst_checker (.*);
